FILE: rtl/core/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants of the dictionary prefix segmenter.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int LTR_W = 5;
  localparam int LEN_W = 4;
  localparam int FUNC_W = 2;
  localparam int BYTE_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_Z = 8'h5A;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } dps_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_letter;
    logic scan_done;
    logic out_free;
  } dps_sts_t;

endpackage

FILE: rtl/core/dps_ctrl.sv
// ----------------------------------------------------------------------------
// dps_ctrl
// Sequencer: accepts an item, walks the dictionary scan for a letter, posts the result of a load or letter.
// ----------------------------------------------------------------------------
module dps_ctrl
  import dps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dps_sts_t sts,
  output dps_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_POST = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.is_letter) begin
          state_nxt = ST_SCAN;
        end else if (in_valid && sts.is_load) begin
          state_nxt = ST_POST;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        cmd.commit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

FILE: rtl/core/dps_dpath.sv
// ----------------------------------------------------------------------------
// dps_dpath
// Dictionary memory, letter window, reach bits, scan compare and result beat.
// ----------------------------------------------------------------------------
module dps_dpath
  import dps_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_WORD    = 10,
  parameter int POS_BITS    = 18
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dps_cmd_t                  cmd,
  output dps_sts_t                  sts,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic [LTR_W*MAX_WORD-1:0] in_word_letters,
  input  logic [LEN_W-1:0]          in_word_len,
  input  logic [BYTE_W-1:0]         in_byte_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [POS_BITS-1:0]       out_prefix_len,
  output logic                      out_load_refused
);

  localparam int WORD_W = LTR_W * MAX_WORD;
  localparam int ENT_W  = WORD_W + LEN_W;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RCH_W  = MAX_WORD + 1;
  localparam int RIDX_W = $clog2(MAX_WORD + 1);

  logic [ENT_W-1:0]    dict_mem [MAX_ENTRIES];
  logic [ENT_W-1:0]    rd_ent_r;
  logic                rd_v_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    scan_idx_r;
  logic [LTR_W-1:0]    win_r [MAX_WORD];
  logic [RCH_W-1:0]    reach_r;
  logic [POS_BITS-1:0] pos_r;
  logic [POS_BITS-1:0] best_r;
  logic                hit_r;
  logic                res_load_r;
  logic                res_refused_r;
  logic                out_valid_r;
  logic [POS_BITS-1:0] out_prefix_len_r;
  logic                out_load_refused_r;

  logic [LTR_W-1:0]    aln [MAX_WORD];
  logic [WORD_W-1:0]   aln_flat;
  logic                is_load;
  logic                is_letter;
  logic                is_restart;
  logic                refused;
  logic                wr_en;
  logic                issue;
  logic                match;
  logic [LEN_W-1:0]    rd_len;
  logic [LEN_W-1:0]    rd_len_m1;
  logic [LTR_W-1:0]    new_code;
  logic [BYTE_W-1:0]   code_full;

  assign is_load    = (in_func == FUNC_LOAD);
  assign is_letter  = (in_func == FUNC_BYTE) && (in_byte_in >= CHAR_A) && (in_byte_in <= CHAR_Z);
  assign is_restart = (in_func == FUNC_RESTART);
  assign refused    = (in_word_len == '0) || (in_word_len > LEN_W'(MAX_WORD)) ||
                      (count_r >= CNT_W'(MAX_ENTRIES));
  assign wr_en      = cmd.accept && is_load && !refused;
  assign code_full  = in_byte_in - CHAR_A;
  assign new_code   = code_full[LTR_W-1:0];

  // align newest letter of the word with the newest window slot
  always_comb begin
    for (int p = 0; p < MAX_WORD; p++) begin
      aln[p] = '0;
      for (int t = 0; t < MAX_WORD; t++) begin
        if (int'(in_word_len) == p + t + 1) begin
          aln[p] = in_word_letters[LTR_W*t +: LTR_W];
        end
      end
      aln_flat[LTR_W*p +: LTR_W] = aln[p];
    end
  end

  assign issue     = cmd.scan && (scan_idx_r < count_r);
  assign rd_len    = rd_ent_r[ENT_W-1 -: LEN_W];
  assign rd_len_m1 = rd_len - LEN_W'(1);

  always_comb begin
    match = (rd_len != '0) && (rd_len <= LEN_W'(MAX_WORD)) &&
            reach_r[rd_len_m1[RIDX_W-1:0]];
    for (int p = 0; p < MAX_WORD; p++) begin
      if ((p < int'(rd_len)) && (rd_ent_r[LTR_W*p +: LTR_W] != win_r[p])) begin
        match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dict_mem[count_r[IDX_W-1:0]] <= {in_word_len, aln_flat};
    end
    if (issue) begin
      rd_ent_r <= dict_mem[scan_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      scan_idx_r  <= '0;
      rd_v_r      <= 1'b0;
      hit_r       <= 1'b0;
      reach_r     <= RCH_W'(1);
      pos_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
      res_load_r  <= 1'b0;
      for (int i = 0; i < MAX_WORD; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      rd_v_r <= issue;
      if (issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
      if (rd_v_r && match) begin
        hit_r <= 1'b1;
      end
      if (cmd.accept) begin
        res_load_r <= is_load;
        if (wr_en) begin
          count_r <= count_r + CNT_W'(1);
        end
        if (is_letter) begin
          win_r[0] <= new_code;
          for (int i = 1; i < MAX_WORD; i++) begin
            win_r[i] <= win_r[i-1];
          end
          if (pos_r != '1) begin
            pos_r <= pos_r + POS_BITS'(1);
          end
          scan_idx_r <= '0;
          hit_r      <= 1'b0;
        end
        if (is_restart) begin
          for (int i = 0; i < MAX_WORD; i++) begin
            win_r[i] <= '0;
          end
          reach_r <= RCH_W'(1);
          pos_r   <= '0;
          best_r  <= '0;
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (!res_load_r) begin
          reach_r <= {reach_r[RCH_W-2:0], hit_r};
          if (hit_r) begin
            best_r <= pos_r;
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_load) begin
      res_refused_r <= refused;
    end
    if (cmd.commit) begin
      out_load_refused_r <= res_load_r && res_refused_r;
      if (res_load_r) begin
        out_prefix_len_r <= '0;
      end else if (hit_r) begin
        out_prefix_len_r <= pos_r;
      end else begin
        out_prefix_len_r <= best_r;
      end
    end
  end

  assign sts.is_load   = is_load;
  assign sts.is_letter = is_letter;
  assign sts.scan_done = !issue && !rd_v_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_prefix_len   = out_prefix_len_r;
  assign out_load_refused = out_load_refused_r;

endmodule

FILE: rtl/core/dictionary_prefix_segmenter.sv
// ----------------------------------------------------------------------------
// dictionary_prefix_segmenter
// Longest dictionary-segmentable prefix of an uppercase letter stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): func 0 stores a dictionary word
// (in_word_letters, in_word_len), func 1 brings a stream byte (in_byte_in),
// func 2 restarts the stream and keeps the dictionary. Bytes other than A to Z
// and func 3 are dropped without a result beat.
// Result channel (out_valid / out_stall): one beat per load and per letter;
// out_prefix_len is the longest segmentable prefix so far (0 on a load beat),
// out_load_refused flags a load with a full dictionary or a bad word length.
// A load's result beat is posted without a scan; a letter's result beat
// follows a scan of the dictionary, since each stored word is read and
// compared in turn through one memory read port. Restart and dropped
// bytes are taken without a scan and leave the input free.
// One item is in work at a time.
// Reset: dictionary empty, stream cleared; no clearing pass is needed.
// A stalled result beat holds in the output register while the next item is
// taken in; the new result waits until that register is free.
// ----------------------------------------------------------------------------
module dictionary_prefix_segmenter
  import dps_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_WORD    = 10,
  parameter int POS_BITS    = 18
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic [LTR_W*MAX_WORD-1:0] in_word_letters,
  input  logic [LEN_W-1:0]          in_word_len,
  input  logic [BYTE_W-1:0]         in_byte_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [POS_BITS-1:0]       out_prefix_len,
  output logic                      out_load_refused
);

  dps_cmd_t cmd;
  dps_sts_t sts;

  dps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dps_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_WORD    (MAX_WORD),
    .POS_BITS    (POS_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_word_letters  (in_word_letters),
    .in_word_len      (in_word_len),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_prefix_len   (out_prefix_len),
    .out_load_refused (out_load_refused)
  );

endmodule

FILE: rtl/core/dps_checker.sv
// ----------------------------------------------------------------------------
// dps_checker
// Port-level checks of the dictionary prefix segmenter.
// ----------------------------------------------------------------------------
module dps_checker
  import dps_pkg::*;
#(
  parameter int POS_BITS = 18
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [FUNC_W-1:0]   in_func,
  input logic [BYTE_W-1:0]   in_byte_in,
  input logic                out_valid,
  input logic                out_stall,
  input logic [POS_BITS-1:0] out_prefix_len,
  input logic                out_load_refused
);

  logic in_acc;
  logic acc_letter;

  assign in_acc     = in_valid && !in_stall;
  assign acc_letter = in_acc && (in_func == FUNC_BYTE) &&
                      (in_byte_in >= CHAR_A) && (in_byte_in <= CHAR_Z);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prefix_len) &&
      $stable(out_load_refused))
    else $error("stalled result beat changed");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_load_refused |-> out_prefix_len == '0)
    else $error("refused load carries a prefix length");

  a_work_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_func == FUNC_LOAD)) || acc_letter |=> in_stall)
    else $error("item taken while a beat was still in work");

  a_restart_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_func == FUNC_RESTART) |=> !in_stall)
    else $error("restart left the input stalled");

endmodule

bind dictionary_prefix_segmenter dps_checker #(
  .POS_BITS (POS_BITS)
) u_dps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_func          (in_func),
  .in_byte_in       (in_byte_in),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_prefix_len   (out_prefix_len),
  .out_load_refused (out_load_refused)
);
